>>> hw/rtl/card_number_luhn_classifier_unit_assert.svh
// Assertion macros for the card number classifier checker
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_UNIT_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CNLC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("card classifier check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CNLC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("card classifier check failed");

`endif

>>> hw/rtl/cnlc_pkg.sv
// Shared constants and types for the card number classifier
`timescale 1ns / 1ps

package cnlc_pkg;

  localparam int CARD_W     = 63;
  localparam int NUM_DIGITS = 19;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int POS_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(CARD_W);
  localparam int COUNT_W    = 5;
  localparam int BRAND_W    = 2;

  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  localparam logic [BRAND_W-1:0] BRAND_NONE  = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_D15   = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_D16_5 = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_LEAD4 = 2'd3;

  typedef struct packed {
    logic             load;   // capture a new card number
    logic             conv;   // one double-dabble shift step
    logic             scan;   // examine one decimal digit
    logic             emit;   // write the result register
    logic [POS_W-1:0] pos;    // digit position during scan, from the right
  } dp_cmd_t;

endpackage

>>> hw/rtl/cnlc_ctrl.sv
// Sequencer for the card number classifier: conversion, digit scan, result handoff
`timescale 1ns / 1ps

module cnlc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cnlc_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [cnlc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       emit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  // result register is free when empty or being drained this cycle
  assign emit      = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load = accept;
    cmd.conv = (state_r == ST_CONV);
    cmd.scan = (state_r == ST_SCAN);
    cmd.emit = emit;
    cmd.pos  = cnt_r[cnlc_pkg::POS_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
          cnt_nxt   = '0;
        end
      end
      ST_CONV: begin
        if (cnt_r == cnlc_pkg::CNT_W'(cnlc_pkg::CARD_W - 1)) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (cnt_r == cnlc_pkg::CNT_W'(cnlc_pkg::NUM_DIGITS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (emit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/cnlc_datapath.sv
// Datapath: bit-serial binary-to-BCD, digit-serial Luhn sum, length and prefix check
`timescale 1ns / 1ps

module cnlc_datapath (
  input  logic                                clk,
  input  cnlc_pkg::dp_cmd_t                   cmd,
  input  logic [cnlc_pkg::CARD_W-1:0]         in_card_number,
  output logic [cnlc_pkg::BRAND_W-1:0]        out_brand,
  output logic                                out_checksum_ok,
  output logic [cnlc_pkg::COUNT_W-1:0]        out_digit_count
);

  logic [cnlc_pkg::CARD_W-1:0]  bin_r, bin_nxt;
  logic [cnlc_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [cnlc_pkg::BCD_W-1:0]   bcd_adj;
  logic [3:0]                   sum_r, sum_nxt;
  logic [cnlc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [3:0]                   hi_r, hi_nxt;
  logic [3:0]                   lo_r, lo_nxt;
  logic [3:0]                   prev_r, prev_nxt;
  logic [cnlc_pkg::BRAND_W-1:0] brand_r;
  logic                         ok_r;
  logic [cnlc_pkg::COUNT_W-1:0] dcount_r;

  logic [3:0]                   digit;
  logic [4:0]                   dbl;
  logic [3:0]                   luhn_d;
  logic [4:0]                   acc;
  logic                         sum_ok;
  logic [cnlc_pkg::BRAND_W-1:0] brand;

  // add-3 correction on every BCD digit ahead of the shift
  always_comb begin
    for (int k = 0; k < cnlc_pkg::NUM_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  // Luhn digit: even positions (counting from one) are doubled and folded
  assign digit = bcd_r[3:0];
  assign dbl   = {digit, 1'b0};
  always_comb begin
    if (!cmd.pos[0]) begin
      luhn_d = digit;
    end else if (dbl >= 5'd10) begin
      luhn_d = 4'(dbl - 5'd9);
    end else begin
      luhn_d = dbl[3:0];
    end
  end
  // running sum kept modulo ten
  assign acc = {1'b0, sum_r} + {1'b0, luhn_d};

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    prev_nxt  = prev_r;
    if (cmd.load) begin
      bin_nxt   = in_card_number;
      bcd_nxt   = '0;
      sum_nxt   = '0;
      count_nxt = '0;
      hi_nxt    = '0;
      lo_nxt    = '0;
      prev_nxt  = '0;
    end else if (cmd.conv) begin
      bcd_nxt = {bcd_adj[cnlc_pkg::BCD_W-2:0], bin_r[cnlc_pkg::CARD_W-1]};
      bin_nxt = {bin_r[cnlc_pkg::CARD_W-2:0], 1'b0};
    end else if (cmd.scan) begin
      bcd_nxt  = {4'd0, bcd_r[cnlc_pkg::BCD_W-1:4]};
      sum_nxt  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
      prev_nxt = digit;
      // the highest nonzero digit seen so far is the leading digit
      if (digit != 4'd0) begin
        count_nxt = cnlc_pkg::COUNT_W'(cmd.pos) + 1'b1;
        hi_nxt    = digit;
        lo_nxt    = prev_r;
      end
    end
  end

  assign sum_ok = (sum_r == 4'd0);

  always_comb begin
    if (!sum_ok) begin
      brand = cnlc_pkg::BRAND_NONE;
    end else if (count_r == cnlc_pkg::LEN_13 && hi_r == 4'd4) begin
      brand = cnlc_pkg::BRAND_LEAD4;
    end else if (count_r == cnlc_pkg::LEN_15 && hi_r == 4'd3 &&
                 (lo_r == 4'd4 || lo_r == 4'd7)) begin
      brand = cnlc_pkg::BRAND_D15;
    end else if (count_r == cnlc_pkg::LEN_16 && hi_r == 4'd5 &&
                 lo_r >= 4'd1 && lo_r <= 4'd5) begin
      brand = cnlc_pkg::BRAND_D16_5;
    end else if (count_r == cnlc_pkg::LEN_16 && hi_r == 4'd4) begin
      brand = cnlc_pkg::BRAND_LEAD4;
    end else begin
      brand = cnlc_pkg::BRAND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    sum_r   <= sum_nxt;
    count_r <= count_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    prev_r  <= prev_nxt;
    if (cmd.emit) begin
      brand_r  <= brand;
      ok_r     <= sum_ok;
      dcount_r <= count_r;
    end
  end

  assign out_brand       = brand_r;
  assign out_checksum_ok = ok_r;
  assign out_digit_count = dcount_r;

endmodule

>>> hw/rtl/card_number_luhn_classifier_unit.sv
// Card number classifier top level: Luhn mod-10 check, digit count and brand
`timescale 1ns / 1ps

// One card number at a time. After a transaction on the input channel the
// number is converted to decimal by a bit-serial double-dabble shifter
// (one input bit per cycle), then the 19 decimal digits are walked from
// the right through a single Luhn adder, and then the result register is
// written: the result becomes valid, and the next number can be taken, in
// the same cycle, so a new number is accepted only once the previous
// result has been written. The result register holds a finished result
// until it is taken while the next number is already being worked on;
// the block stalls only if a second result is finished before the first
// is taken.

module card_number_luhn_classifier_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cnlc_pkg::CARD_W-1:0]   in_card_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cnlc_pkg::BRAND_W-1:0]  out_brand,
  output logic                          out_checksum_ok,
  output logic [cnlc_pkg::COUNT_W-1:0]  out_digit_count
);

  cnlc_pkg::dp_cmd_t cmd;

  cnlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cnlc_datapath u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_card_number  (in_card_number),
    .out_brand       (out_brand),
    .out_checksum_ok (out_checksum_ok),
    .out_digit_count (out_digit_count)
  );

endmodule

>>> hw/rtl/cnlc_checker.sv
// Port-level checker for the card number classifier, bound to the top level
`timescale 1ns / 1ps
`include "card_number_luhn_classifier_unit_assert.svh"

module cnlc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cnlc_pkg::BRAND_W-1:0]  out_brand,
  input logic                          out_checksum_ok,
  input logic [cnlc_pkg::COUNT_W-1:0]  out_digit_count
);

  // a stalled result keeps its fields
  `CNLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_brand) && $stable(out_checksum_ok) && $stable(out_digit_count))

  // one number at a time: busy right after a transaction
  `CNLC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a brand is only reported on a passing checksum
  `CNLC_ASSERT_NOW(a_brand_needs_sum, out_valid && out_brand != cnlc_pkg::BRAND_NONE, out_checksum_ok)

  // brand agrees with the digit count
  `CNLC_ASSERT_NOW(a_brand_length, out_valid && out_brand != cnlc_pkg::BRAND_NONE, (out_brand == cnlc_pkg::BRAND_D15 && out_digit_count == cnlc_pkg::LEN_15) || (out_brand == cnlc_pkg::BRAND_D16_5 && out_digit_count == cnlc_pkg::LEN_16) || (out_brand == cnlc_pkg::BRAND_LEAD4 && (out_digit_count == cnlc_pkg::LEN_13 || out_digit_count == cnlc_pkg::LEN_16)))

  // a 63-bit number never has more than 19 digits
  `CNLC_ASSERT_NOW(a_count_range, out_valid, out_digit_count <= 5'(cnlc_pkg::NUM_DIGITS))

endmodule

bind card_number_luhn_classifier_unit cnlc_checker u_cnlc_checker (.*);
